/* hdl/rbf_pkg.sv */
// Shared widths, APB constants and the controller-to-datapath command type.
`default_nettype none

package rbf_pkg;

    // Fixed field widths of the stream and configuration interfaces.
    localparam int SAMPLE_W   = 8;
    localparam int TAPS_W     = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // Reset value of the filter length register.
    localparam logic [TAPS_W-1:0] TAPS_RESET = 4'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic shift_en;    // Shift one value into the window.
        logic shift_zero;  // The shifted value is zero (tail of the row).
        logic load_out;    // Load the output register with sum / taps.
        logic clear;       // Clear the window and the running sum.
    } rbf_cmd_t;

endpackage

`default_nettype wire

/* hdl/rbf_datapath.sv */
// Window shift line, running sum and reciprocal divider with output register.
`default_nettype none

module rbf_datapath #(
    parameter int MAX_TAPS = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire rbf_pkg::rbf_cmd_t                cmd,
    input  wire logic [$clog2(MAX_TAPS+1)-1:0]    eff_n,
    input  wire logic [rbf_pkg::SAMPLE_W-1:0]     in_sample,
    output logic      [rbf_pkg::SAMPLE_W-1:0]     out_data
);

    localparam int NW      = $clog2(MAX_TAPS + 1);
    localparam int IW      = $clog2(MAX_TAPS);
    localparam int SUM_W   = rbf_pkg::SAMPLE_W + IW;
    localparam int SHIFT   = SUM_W + NW;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    logic [rbf_pkg::SAMPLE_W-1:0] window_reg [MAX_TAPS];
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;
    logic [rbf_pkg::SAMPLE_W-1:0] out_data_reg;
    logic [rbf_pkg::SAMPLE_W-1:0] out_data_next;
    logic [rbf_pkg::SAMPLE_W-1:0] shift_val;
    logic [rbf_pkg::SAMPLE_W-1:0] drop_val;
    logic [NW-1:0]                tap_last;
    logic [RECIP_W-1:0]           recip_tab [2**NW];
    logic [PROD_W-1:0]            product;

    // Reciprocal table: ceil(2^SHIFT / n). With sum * n below 2^SHIFT the
    // truncated product equals the exact truncated quotient.
    for (genvar g = 0; g < 2**NW; g++) begin : g_recip
        if (g >= 1 && g <= MAX_TAPS) begin : g_used
            localparam longint unsigned RECIP = ((64'd1 << SHIFT) + g - 1) / g;
            assign recip_tab[g] = RECIP_W'(RECIP);
        end else begin : g_unused
            assign recip_tab[g] = '0;
        end
    end

    always_comb begin
        shift_val     = cmd.shift_zero ? '0 : in_sample;
        tap_last      = NW'(eff_n - NW'(1));
        drop_val      = window_reg[tap_last[IW-1:0]];
        sum_next      = sum_reg - SUM_W'(drop_val) + SUM_W'(shift_val);
        product       = PROD_W'(sum_reg) * PROD_W'(recip_tab[eff_n]);
        out_data_next = product[SHIFT +: rbf_pkg::SAMPLE_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                window_reg[k] <= '0;
            end
            sum_reg <= '0;
        end else if (cmd.shift_en) begin
            for (int k = MAX_TAPS - 1; k > 0; k--) begin
                window_reg[k] <= window_reg[k-1];
            end
            window_reg[0] <= shift_val;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

/* hdl/rbf_ctrl.sv */
// Controller state machine: stream handshakes, row tail sequencing, output valid.
`default_nettype none

module rbf_ctrl #(
    parameter int MAX_TAPS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [$clog2(MAX_TAPS+1)-1:0] eff_n,
    input  wire logic                          cfg_write,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tlast,
    output logic                               s_tready,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic                               m_tlast,
    output rbf_pkg::rbf_cmd_t                  cmd
);

    localparam int NW = $clog2(MAX_TAPS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_TAIL
    } state_t;

    state_t        state_reg, state_next;
    logic          pend_end_reg, pend_end_next;
    logic [NW-1:0] tail_left_reg, tail_left_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          m_tlast_reg, m_tlast_next;
    logic          out_free;
    logic          accept;

    always_comb begin
        out_free       = !m_tvalid_reg || m_tready;
        state_next     = state_reg;
        pend_end_next  = pend_end_reg;
        tail_left_next = tail_left_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tlast_next   = m_tlast_reg;
        cmd            = '0;
        cmd.clear      = cfg_write;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EMIT: begin
                s_tready = out_free && !pend_end_reg;
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = pend_end_reg && (tail_left_reg == '0);
                    if (pend_end_reg) begin
                        if (tail_left_reg == '0) begin
                            cmd.clear     = 1'b1;
                            pend_end_next = 1'b0;
                            state_next    = ST_IDLE;
                        end else begin
                            state_next = ST_TAIL;
                        end
                    end else if (!s_tvalid) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                cmd.shift_en   = 1'b1;
                cmd.shift_zero = 1'b1;
                tail_left_next = NW'(tail_left_reg - NW'(1));
                state_next     = ST_EMIT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        accept = s_tvalid && s_tready;
        if (accept) begin
            cmd.shift_en   = 1'b1;
            pend_end_next  = s_tlast;
            tail_left_next = NW'(eff_n - NW'(1));
            state_next     = ST_EMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_end_reg  <= 1'b0;
            tail_left_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tlast_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_end_reg  <= pend_end_next;
            tail_left_reg <= tail_left_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tlast_reg   <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* hdl/row_box_filter_unit.sv */
// Top level of the row box filter: APB register, controller and datapath.
//
// Horizontal box filter for one row of 8-bit coverage samples. Every sample
// accepted on the s_ stream enters a window of the last taps samples, and the
// block sends the window sum divided by taps (truncated) on the m_ stream.
// The sample marked with s_tlast also produces taps-1 tail outputs as if zero
// samples followed, so a row of S samples yields S+taps-1 outputs, the last
// one marked with m_tlast; the window is then cleared for the next row.
// Timing: a row streams at one sample per cycle while m_tready stays high;
// the first sample after an idle cycle passes the running sum register and
// then the output register before it shows up on m_. The sample that ends a
// row blocks the input until its tail is done: each tail output needs a TAIL
// state to shift a zero through the window adder and an EMIT state for the
// reciprocal multiplier to form the quotient into the output register. The
// output register holds a finished result while the next sample is taken.
// The taps register (APB address 0, bits 3:0, reset 2) is taken as 1 when
// zero and as MAX_TAPS when larger; writing it clears the window. Write it
// only while no row is in flight.
`default_nettype none

module row_box_filter_unit #(
    parameter int MAX_TAPS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // APB configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rbf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [rbf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [rbf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] sample
    input  wire logic                               s_tlast,   // row_end
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [7:0]                         m_tdata,   // [7:0] filtered
    output logic                                    m_tlast    // last
);

    localparam int NW = $clog2(MAX_TAPS + 1);

    logic [rbf_pkg::TAPS_W-1:0] taps_reg;
    logic [NW-1:0]              eff_n;
    logic                       cfg_write;
    rbf_pkg::rbf_cmd_t          cmd;

    // There is a single register, so every completed write transaction
    // lands in it regardless of the address bits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = rbf_pkg::APB_DATA_W'(taps_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= rbf_pkg::TAPS_RESET;
        end else if (cfg_write) begin
            taps_reg <= pwdata[rbf_pkg::TAPS_W-1:0];
        end
    end

    // A length of zero behaves as a pass-through; lengths beyond the window
    // depth saturate to the full window.
    always_comb begin
        if (taps_reg == '0) begin
            eff_n = NW'(1);
        end else if (32'(taps_reg) > MAX_TAPS) begin
            eff_n = NW'(MAX_TAPS);
        end else begin
            eff_n = NW'(taps_reg);
        end
    end

    rbf_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_n     (eff_n),
        .cfg_write (cfg_write),
        .s_tvalid  (s_tvalid),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .cmd       (cmd)
    );

    rbf_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .eff_n     (eff_n),
        .in_sample (s_tdata),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

/* hdl/rbf_checker.sv */
// Port-level checker for the row box filter and its bind to the top level.
`default_nettype none

module rbf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The sample that ends a row blocks the input while its tail is produced.
    a_row_end_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during row tail");

    // An accepted sample, with the sink ready after it, gives a valid result.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted sample gave no result");

endmodule

bind row_box_filter_unit rbf_checker u_rbf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the row box filter: directed rows, random rows, taps changes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TAPS = 8;
    localparam int CLK_HALF = 6;

    // The taps register is register 0, so it sits at byte address 0.
    localparam logic [rbf_pkg::APB_ADDR_W-1:0] TAPS_ADDR = '0;

    // A sample that ends a row keeps the block busy through its tail outputs, so
    // this pause is enough to let the block settle before the register changes.
    localparam int DRAIN_CYCLES = 2 * MAX_TAPS + 4;

    // Cycles without any transaction on either stream or the APB port before
    // the run is declared hung. The longest quiet stretch of a correct run is
    // the settle pause above plus a sender gap and a receiver stall.
    localparam int STALL_LIMIT = 2000;

    // One source byte and its end-of-row marker.
    typedef struct packed {
        logic [rbf_pkg::SAMPLE_W-1:0] sample;
        logic                         row_end;
    } row_item_t;

    // One filtered output byte and its end-of-row marker.
    typedef struct packed {
        logic [rbf_pkg::SAMPLE_W-1:0] filtered;
        logic                         last;
    } avg_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [rbf_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [rbf_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [rbf_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = '0;    // [7:0] sample
    logic                           s_tlast  = 1'b0;  // row_end
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;          // [7:0] filtered
    logic                           m_tlast;          // last

    row_box_filter_unit #(
        .MAX_TAPS (MAX_TAPS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Samples waiting to be sent, and the filtered bytes still owed by the block.
    row_item_t   row_samples[$];
    avg_result_t avg_expected[$];

    // Shadow of the filter state: the taps register as written, the window of
    // recent samples (newest at index 0) and the sum of the active part of it.
    logic [rbf_pkg::TAPS_W-1:0]   taps_setting = rbf_pkg::TAPS_RESET;
    logic [rbf_pkg::SAMPLE_W-1:0] box_window[MAX_TAPS];
    logic [10:0]                  box_sum = '0;

    int samples_queued = 0;
    int samples_taken  = 0;
    int mismatches     = 0;

    // Sender pacing and receiver stall pattern.
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          stall_cycle = 0;
    int          ready_mode  = 0;
    row_item_t   next_item;
    avg_result_t want;
    int          quiet_cycles = 0;

    initial begin
        foreach (box_window[k]) box_window[k] = '0;
    end

    // A taps write and the end of every row both empty the window.
    task automatic clear_box_window();
        foreach (box_window[k]) box_window[k] = '0;
        box_sum = '0;
    endtask

    // Shift one value into the window and queue the resulting average.
    task automatic push_box_output(input logic [7:0] v, input int unsigned n,
                                   input logic is_last);
        avg_result_t r;
        box_sum = box_sum - box_window[n - 1];
        for (int k = MAX_TAPS - 1; k > 0; k--) box_window[k] = box_window[k - 1];
        box_window[0] = v;
        box_sum = box_sum + v;
        r.filtered = 8'(box_sum / n);
        r.last     = is_last;
        avg_expected.push_back(r);
    endtask

    // Work out every output caused by one accepted sample. A zero taps value
    // acts as a pass-through and values above MAX_TAPS saturate. The sample
    // that ends a row also flushes the window with taps-1 zero samples.
    task automatic box_filter_sample(input logic [7:0] smp, input logic row_end);
        int unsigned n;
        n = (taps_setting == 0) ? 1 :
            (taps_setting > MAX_TAPS) ? MAX_TAPS : taps_setting;
        push_box_output(smp, n, row_end && (n == 1));
        if (row_end) begin
            for (int t = 1; t < n; t++) push_box_output(8'd0, n, t == n - 1);
            clear_box_window();
        end
    endtask

    // Driver. The current transaction is held until it is accepted; then the
    // next sample is taken from the queue unless the sender is in a gap.
    // Bursts of random length alternate with random gaps, and half of the gaps
    // are empty so that long back-to-back stretches occur too.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                box_filter_sample(s_tdata, s_tlast);
                samples_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (row_samples.size() > 0) begin
                    next_item = row_samples.pop_front();
                    s_tdata  <= next_item.sample;
                    s_tlast  <= next_item.row_end;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each accepted result is checked against the oldest expected
    // one. The receiver's ready mode is picked at random among always ready,
    // random stalls, ready one cycle in four, and a fixed run of seven ready
    // cycles out of eleven.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_cycle = 0;
            ready_mode  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (avg_expected.size() == 0) begin
                    $error("unexpected result transaction: filtered=%0d last=%0b",
                           m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = avg_expected.pop_front();
                    if (m_tdata !== want.filtered) begin
                        $error("filtered mismatch: expected %0d, actual %0d",
                               want.filtered, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            stall_cycle++;
            if (stall_cycle % 48 == 0) ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 6);
                2:       m_tready <= (stall_cycle % 4 == 0);
                default: m_tready <= (stall_cycle % 11 < 7);
            endcase
        end
    end

    // Watchdog. Any transaction on either stream or an APB access counts as
    // progress; a long quiet stretch means the block has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_sample(input logic [7:0] v, input logic row_end);
        row_item_t it;
        it.sample  = v;
        it.row_end = row_end;
        row_samples.push_back(it);
        samples_queued++;
    endtask

    // Queue a row of random content: full-range bytes, only the extremes,
    // one constant value, or small values.
    task automatic add_row(input int len, input logic close_row, input int style);
        logic [7:0] level;
        logic [7:0] v;
        level = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            case (style)
                0:       v = 8'($urandom_range(0, 255));
                1:       v = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                2:       v = level;
                default: v = 8'($urandom_range(0, 15));
            endcase
            add_sample(v, close_row && (i == len - 1));
        end
    endtask

    // Wait until every queued sample is accepted and every output has come,
    // then give the block time to settle.
    task automatic wait_rows_drained();
        while (!(samples_taken == samples_queued && avg_expected.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle. pready is always high, so the
    // register takes the value at the edge that ends the access cycle, and the
    // shadow state follows at that same edge.
    task automatic write_taps(input logic [rbf_pkg::TAPS_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TAPS_ADDR;
        pwdata  <= rbf_pkg::APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        taps_setting = value;
        clear_box_window();
    endtask

    initial begin
        int                         quota;
        int                         len;
        logic [rbf_pkg::TAPS_W-1:0] tv;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Reset taps of two: a full row and a one-sample row.
        add_sample(8'd255, 1'b0);
        add_sample(8'd255, 1'b0);
        add_sample(8'd0,   1'b0);
        add_sample(8'd255, 1'b1);
        add_sample(8'd255, 1'b1);
        wait_rows_drained();

        // Largest window filled with full coverage: the widest running sum.
        write_taps(4'd8);
        for (int i = 0; i < 8; i++) add_sample(8'd255, i == 7);
        wait_rows_drained();

        // One tap passes the bytes through and marks the row end directly.
        write_taps(4'd1);
        add_sample(8'h00, 1'b0);
        add_sample(8'hFF, 1'b0);
        add_sample(8'hAA, 1'b0);
        add_sample(8'h55, 1'b1);
        wait_rows_drained();

        // Zero taps behaves as one tap.
        write_taps(4'd0);
        add_sample(8'd200, 1'b0);
        add_sample(8'd7,   1'b1);
        wait_rows_drained();

        // The largest register value saturates to MAX_TAPS.
        write_taps(4'd15);
        add_sample(8'd255, 1'b0);
        add_sample(8'd0,   1'b0);
        add_sample(8'd255, 1'b1);
        wait_rows_drained();

        // A taps write in the middle of a row drops the partial window.
        write_taps(4'd3);
        add_sample(8'd9,   1'b0);
        add_sample(8'd250, 1'b0);
        add_sample(8'd100, 1'b0);
        wait_rows_drained();
        write_taps(4'd5);
        add_sample(8'd60, 1'b1);
        wait_rows_drained();

        // Random part: whole rows of random length and content under a range
        // of taps settings, the extremes first. Some phases leave a row open
        // so that the next taps write lands mid-row.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:       tv = 4'd1;
                1:       tv = 4'd8;
                2:       tv = 4'd0;
                3:       tv = 4'd15;
                default: tv = 4'($urandom_range(0, 15));
            endcase
            write_taps(tv);
            quota = samples_queued + 14;
            while (samples_queued < quota) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30)
                                                  : $urandom_range(1, 8);
                add_row(len, 1'b1, $urandom_range(0, 3));
            end
            if ($urandom_range(0, 2) == 0) add_row($urandom_range(1, 5), 1'b0, 0);
            wait_rows_drained();
        end

        if (mismatches == 0 && avg_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
